// ===== hdl/bqd_pkg.sv =====
package bqd_pkg;

  localparam int WORD_W = 32;
  localparam int LEN_W = 7;
  localparam int IDX_W = 6;
  localparam int OP_W = 3;
  localparam int DIV_STEPS = 32;

  // operation codes carried in the input beat
  localparam logic [OP_W-1:0] OP_WR_DIVIDEND = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_DIVISOR  = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_LEN     = 3'd2;
  localparam logic [OP_W-1:0] OP_DIGIT       = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_DIVIDEND = 3'd4;

  // controls for the shared multiply-subtract unit
  typedef struct packed {
    logic clr;
    logic mul_en;
    logic sub_en;
  } ms_ctrl_t;

endpackage

// ===== hdl/bqd_div.sv =====
module bqd_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bqd_pkg::WORD_W-1:0] num,
  input  logic [bqd_pkg::WORD_W-1:0] den,
  output logic                       done,
  output logic [bqd_pkg::WORD_W-1:0] quo
);

  localparam int CNT_W = $clog2(bqd_pkg::DIV_STEPS + 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [bqd_pkg::WORD_W-1:0] rem_r, rem_nxt;
  logic [bqd_pkg::WORD_W-1:0] quo_r, quo_nxt;
  logic [bqd_pkg::WORD_W-1:0] den_r, den_nxt;
  logic [bqd_pkg::WORD_W:0]   rem_sh;
  logic [bqd_pkg::WORD_W:0]   rem_sub;
  logic                       ge;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[bqd_pkg::WORD_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(bqd_pkg::DIV_STEPS);
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[bqd_pkg::WORD_W-1:0] : rem_sh[bqd_pkg::WORD_W-1:0];
      quo_nxt = {quo_r[bqd_pkg::WORD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== hdl/bqd_mulsub.sv =====
module bqd_mulsub (
  input  logic                       clk,
  input  bqd_pkg::ms_ctrl_t          ctrl,
  input  logic [bqd_pkg::WORD_W-1:0] mult,
  input  logic [bqd_pkg::WORD_W-1:0] dvs_word,
  input  logic [bqd_pkg::WORD_W-1:0] dvd_word,
  output logic [bqd_pkg::WORD_W-1:0] diff
);

  localparam int W = bqd_pkg::WORD_W;

  logic [2*W-1:0] prod_r;
  logic [W-1:0]   a_r;
  logic [W-1:0]   carry_r;
  logic           borrow_r;
  logic [2*W-1:0] sum;
  logic [W:0]     diff_x;

  // add carry to product, then subtract low half and borrow
  always_comb begin
    sum    = prod_r + {{W{1'b0}}, carry_r};
    diff_x = {1'b0, a_r} - {1'b0, sum[W-1:0]} - {{W{1'b0}}, borrow_r};
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= {{W{1'b0}}, dvs_word} * {{W{1'b0}}, mult};
      a_r    <= dvd_word;
    end
    if (ctrl.clr) begin
      carry_r  <= '0;
      borrow_r <= 1'b0;
    end else if (ctrl.sub_en) begin
      carry_r  <= sum[2*W-1:W];
      borrow_r <= diff_x[W];
    end
  end

  assign diff = diff_x[W-1:0];

endmodule

// ===== hdl/bignum_quotient_digit.sv =====
// channel | dir | ports                          | contents
// in      | in  | in_tvalid/in_tready/in_tdata   | tuser: op; tdata: index, word, lengths
// out     | out | out_tvalid/out_tready/out_tdata | digit, read word, dividend length
//
// Write, length and unknown ops go straight to S_FINISH; a read passes S_RDWAIT first.
// A digit with a dividend shorter than the divisor also goes straight to S_FINISH.
// Otherwise the top divisor word is read and the divider forms a trial digit;
// then each of up to two multiply-subtract passes over divisor_len words reads,
// multiplies and subtracts each word in turn, and the trims and the compare scan
// the dividend words one at a time.
// in_tready is high only while the sequencer is idle; a result waits in the
// output register until taken. rst_n is synchronous; the word stores are not
// cleared.
module bignum_quotient_digit #(
  parameter int MAX_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // op
  input  logic [55:0] in_tdata,   // word_index, word_value, dividend_len_in, divisor_len_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // digit, read_word, dividend_len_out
);

  localparam int W = bqd_pkg::WORD_W;
  localparam int LW = bqd_pkg::LEN_W;
  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RDWAIT, S_TOPRD, S_DIVWAIT, S_MS_RD, S_MS_MUL, S_MS_SUB, S_PASS_END,
    S_TRIM, S_TRIM_RD, S_TRIM_CHK, S_CMP, S_CMP_STEP, S_CMP_RD, S_CMP_CHK,
    S_BN_RD, S_BN_CHK, S_FINISH
  } state_t;

  logic [bqd_pkg::IDX_W-1:0] in_idx;
  logic [W-1:0]              in_val;
  logic [LW-1:0]             in_dl, in_sl, sl_eff;
  logic                      idx_ok;

  assign in_idx = in_tdata[5:0];
  assign in_val = in_tdata[37:6];
  assign in_dl  = in_tdata[44:38];
  assign in_sl  = in_tdata[51:45];
  assign idx_ok = 32'(in_idx) < MAX_WORDS;

  state_t        state_r, state_nxt;
  logic [LW-1:0] dd_len_r, dd_len_nxt, ds_len_r, ds_len_nxt;
  logic [LW-1:0] w_r, w_nxt, bn_r, bn_nxt;
  logic [AW-1:0] idx_r, idx_nxt, top_r, top_nxt;
  logic [W-1:0]  q_r, q_nxt, m_r, m_nxt, last_r, last_nxt, rdw_r, rdw_nxt;
  logic          pass_r, pass_nxt, rd_ok_r, rd_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [W-1:0]  out_digit_r, out_digit_nxt, out_rd_r, out_rd_nxt;
  logic [LW-1:0] out_len_r, out_len_nxt;

  logic [W-1:0]  dd_mem [MAX_WORDS];
  logic [W-1:0]  ds_mem [MAX_WORDS];
  logic [W-1:0]  dd_rdata, ds_rdata;
  logic [AW-1:0] rd_addr, dd_wa, ds_wa;
  logic [W-1:0]  dd_wd, ds_wd;
  logic          dd_we, ds_we;

  logic          div_start, div_done;
  logic [W-1:0]  div_quo;
  logic [W-1:0]  ms_diff;
  bqd_pkg::ms_ctrl_t ms_ctrl;
  logic          go_sub, trim_fin;

  bqd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dd_rdata),
    .den   (ds_rdata + W'(1)),
    .done  (div_done),
    .quo   (div_quo)
  );

  bqd_mulsub u_mulsub (
    .clk      (clk),
    .ctrl     (ms_ctrl),
    .mult     (m_r),
    .dvs_word (ds_rdata),
    .dvd_word (dd_rdata),
    .diff     (ms_diff)
  );

  // word stores with registered reads
  always_ff @(posedge clk) begin
    if (dd_we) begin
      dd_mem[dd_wa] <= dd_wd;
    end
    dd_rdata <= dd_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ds_we) begin
      ds_mem[ds_wa] <= ds_wd;
    end
    ds_rdata <= ds_mem[rd_addr];
  end

  // pick the read address for the next cycle
  always_comb begin
    case (state_r)
      S_IDLE:    rd_addr = (in_tuser == bqd_pkg::OP_DIGIT) ? AW'(ds_len_r - LW'(1))
                                                           : AW'(in_idx);
      S_MS_RD:   rd_addr = idx_r;
      S_TRIM_RD: rd_addr = AW'(w_r - LW'(1));
      S_CMP_RD:  rd_addr = AW'(w_r - LW'(1));
      S_BN_RD:   rd_addr = AW'(bn_r);
      default:   rd_addr = idx_r;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);
  assign sl_eff = (in_sl == '0) ? LW'(1) : in_sl;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    dd_len_nxt = dd_len_r;
    ds_len_nxt = ds_len_r;
    w_nxt      = w_r;
    bn_nxt     = bn_r;
    idx_nxt    = idx_r;
    top_nxt    = top_r;
    q_nxt      = q_r;
    m_nxt      = m_r;
    last_nxt   = last_r;
    rdw_nxt    = rdw_r;
    pass_nxt   = pass_r;
    rd_ok_nxt  = rd_ok_r;
    out_valid_nxt = out_valid_r;
    out_digit_nxt = out_digit_r;
    out_rd_nxt    = out_rd_r;
    out_len_nxt   = out_len_r;
    dd_we = 1'b0;
    dd_wa = idx_r;
    dd_wd = ms_diff;
    ds_we = 1'b0;
    ds_wa = AW'(in_idx);
    ds_wd = in_val;
    div_start = 1'b0;
    ms_ctrl   = '0;
    go_sub    = 1'b0;
    trim_fin  = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          q_nxt     = '0;
          rdw_nxt   = '0;
          rd_ok_nxt = idx_ok;
          state_nxt = S_FINISH;
          case (in_tuser)
            bqd_pkg::OP_WR_DIVIDEND: begin
              dd_we = idx_ok;
              dd_wa = AW'(in_idx);
              dd_wd = in_val;
            end
            bqd_pkg::OP_WR_DIVISOR: begin
              ds_we = idx_ok;
            end
            bqd_pkg::OP_SET_LEN: begin
              dd_len_nxt = (32'(in_dl) > MAX_WORDS) ? LW'(MAX_WORDS) : in_dl;
              ds_len_nxt = (32'(sl_eff) > MAX_WORDS) ? LW'(MAX_WORDS) : sl_eff;
            end
            bqd_pkg::OP_DIGIT: begin
              if (dd_len_r >= ds_len_r) begin
                top_nxt   = AW'(ds_len_r - LW'(1));
                bn_nxt    = ds_len_r - LW'(1);
                state_nxt = S_TOPRD;
              end
            end
            bqd_pkg::OP_RD_DIVIDEND: begin
              state_nxt = S_RDWAIT;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        rdw_nxt   = rd_ok_r ? dd_rdata : '0;
        state_nxt = S_FINISH;
      end
      S_TOPRD: begin
        // top divisor word all ones: trial digit is zero
        if (ds_rdata == '1) begin
          state_nxt = S_CMP;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVWAIT;
        end
      end
      S_DIVWAIT: begin
        if (div_done) begin
          q_nxt = div_quo;
          if (div_quo == '0) begin
            state_nxt = S_CMP;
          end else begin
            m_nxt       = div_quo;
            pass_nxt    = 1'b0;
            idx_nxt     = '0;
            ms_ctrl.clr = 1'b1;
            state_nxt   = S_MS_RD;
          end
        end
      end
      S_MS_RD: begin
        state_nxt = S_MS_MUL;
      end
      S_MS_MUL: begin
        ms_ctrl.mul_en = 1'b1;
        state_nxt      = S_MS_SUB;
      end
      S_MS_SUB: begin
        ms_ctrl.sub_en = 1'b1;
        dd_we    = 1'b1;
        last_nxt = ms_diff;
        if (idx_r == top_r) begin
          state_nxt = S_PASS_END;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_MS_RD;
        end
      end
      S_PASS_END: begin
        if (pass_r) begin
          state_nxt = S_BN_RD;
        end else if (last_r == '0) begin
          w_nxt     = LW'(top_r);
          state_nxt = S_TRIM;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_TRIM: begin
        if (w_r > LW'(1)) begin
          state_nxt = S_TRIM_RD;
        end else begin
          trim_fin = 1'b1;
        end
      end
      S_TRIM_RD: begin
        state_nxt = S_TRIM_CHK;
      end
      S_TRIM_CHK: begin
        if (dd_rdata == '0) begin
          w_nxt     = w_r - LW'(1);
          state_nxt = S_TRIM;
        end else begin
          trim_fin = 1'b1;
        end
      end
      S_CMP: begin
        if (dd_len_r != ds_len_r) begin
          if (dd_len_r > ds_len_r) begin
            go_sub = 1'b1;
          end else begin
            state_nxt = S_FINISH;
          end
        end else begin
          w_nxt     = dd_len_r;
          state_nxt = S_CMP_STEP;
        end
      end
      S_CMP_STEP: begin
        if (w_r == '0) begin
          go_sub = 1'b1;
        end else begin
          state_nxt = S_CMP_RD;
        end
      end
      S_CMP_RD: begin
        state_nxt = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (dd_rdata != ds_rdata) begin
          if (dd_rdata > ds_rdata) begin
            go_sub = 1'b1;
          end else begin
            state_nxt = S_FINISH;
          end
        end else begin
          w_nxt     = w_r - LW'(1);
          state_nxt = S_CMP_STEP;
        end
      end
      S_BN_RD: begin
        state_nxt = S_BN_CHK;
      end
      S_BN_CHK: begin
        if (dd_rdata == '0) begin
          w_nxt     = bn_r;
          state_nxt = S_TRIM;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_digit_nxt = q_r;
          out_rd_nxt    = rdw_r;
          out_len_nxt   = dd_len_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // close a trim: set the length, then compare or finish
    if (trim_fin) begin
      dd_len_nxt = w_r;
      if (pass_r) begin
        state_nxt = S_FINISH;
      end else begin
        bn_nxt    = w_r;
        state_nxt = S_CMP;
      end
    end

    // dividend still at least divisor: bump digit, subtract once more
    if (go_sub) begin
      q_nxt       = q_r + W'(1);
      m_nxt       = W'(1);
      pass_nxt    = 1'b1;
      idx_nxt     = '0;
      ms_ctrl.clr = 1'b1;
      state_nxt   = S_MS_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dd_len_r    <= '0;
      ds_len_r    <= LW'(1);
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dd_len_r    <= dd_len_nxt;
      ds_len_r    <= ds_len_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
    end
    w_r         <= w_nxt;
    bn_r        <= bn_nxt;
    idx_r       <= idx_nxt;
    top_r       <= top_nxt;
    q_r         <= q_nxt;
    m_r         <= m_nxt;
    last_r      <= last_nxt;
    rdw_r       <= rdw_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_digit_r <= out_digit_nxt;
    out_rd_r    <= out_rd_nxt;
    out_len_r   <= out_len_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_len_r, out_rd_r, out_digit_r};

endmodule
